>>> rtl/core/running_light_speed_controller_defines.svh
// Assertion macros for the running light speed controller.
// Each use names a label, a property expression and a message.
`ifndef RUNNING_LIGHT_SPEED_CONTROLLER_DEFINES_SVH
`define RUNNING_LIGHT_SPEED_CONTROLLER_DEFINES_SVH

`ifndef SYNTH

// Checked on every rising edge outside reset
`define RLSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define RLSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RLSC_ASSERT(lbl, prop, msg)
`define RLSC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/core/rlsc_pkg.sv
package rlsc_pkg;

  // Ring size and field widths
  localparam int NUM_LEDS   = 4;
  localparam int PERIOD_W   = 31;
  localparam int BUTTON_W   = 4;
  localparam int LED_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;

  // Button bit positions
  localparam int BTN_RUN  = 0;
  localparam int BTN_DIR  = 1;
  localparam int BTN_FAST = 2;
  localparam int BTN_SLOW = 3;

  // Register values after reset
  localparam logic [PERIOD_W-1:0] INITIAL_PERIOD_RST = PERIOD_W'(50000000);
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST     = PERIOD_W'(12500000);
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST     = PERIOD_W'(100000000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_PERIOD = 2'd0,
    CFG_MIN_PERIOD     = 2'd1,
    CFG_MAX_PERIOD     = 2'd2
  } cfg_index_t;

  // Request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  typedef struct packed {
    logic                    we;
    logic [CFG_IDX_W-1:0]    index;
    logic [PERIOD_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic                    req_type;
    logic [BUTTON_W-1:0]     buttons;
  } item_t;

  // Packed so that leds sits in the lowest bits
  typedef struct packed {
    logic [PERIOD_W-1:0]     step_period;
    logic                    reverse;
    logic                    is_running;
    logic                    stepped;
    logic [LED_OUT_W-1:0]    leds;
  } result_t;

endpackage

>>> rtl/core/rlsc_step.sv
`include "running_light_speed_controller_defines.svh"

module rlsc_step
  import rlsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [NUM_LEDS-1:0] pattern, pattern_next;
  logic                run_flag, run_flag_next;
  logic                dir_flag, dir_flag_next;
  logic [PERIOD_W-1:0] period, period_next;
  logic [PERIOD_W-1:0] countdown, countdown_next;
  logic [BUTTON_W-1:0] last_buttons, last_buttons_next;
  logic [PERIOD_W-1:0] min_period, max_period;

  logic                              stepped;
  logic [BUTTON_W-1:0]               rise;
  logic [PERIOD_W-1:0]               halved;
  logic [PERIOD_W-1:0]               p_fast;
  logic [PERIOD_W:0]                 doubled;
  logic [NUM_LEDS+LED_OUT_W-1:0]     pattern_ext;

  // Next state for one request
  always_comb begin
    pattern_next      = pattern;
    run_flag_next     = run_flag;
    dir_flag_next     = dir_flag;
    period_next       = period;
    countdown_next    = countdown;
    last_buttons_next = last_buttons;
    stepped           = 1'b0;
    rise              = item.buttons & ~last_buttons;
    halved            = period >> 1;
    p_fast            = period;
    doubled           = '0;

    if (fire) begin
      if (item.req_type == REQ_TICK) begin
        if (countdown <= PERIOD_W'(1)) begin
          countdown_next = period;
          if (run_flag) begin
            stepped = 1'b1;
            if (!dir_flag) begin
              pattern_next = {pattern[NUM_LEDS-2:0], pattern[NUM_LEDS-1]};
            end else begin
              pattern_next = {pattern[0], pattern[NUM_LEDS-1:1]};
            end
          end
        end else begin
          countdown_next = countdown - PERIOD_W'(1);
        end
      end else begin
        last_buttons_next = item.buttons;
        if (rise[BTN_RUN]) begin
          run_flag_next = ~run_flag;
        end
        if (rise[BTN_DIR]) begin
          dir_flag_next = ~dir_flag;
        end
        // faster: halve and clamp to the minimum
        if (rise[BTN_FAST] && (period > min_period)) begin
          p_fast         = (halved < min_period) ? min_period : halved;
          countdown_next = p_fast;
        end
        period_next = p_fast;
        // slower: double and clamp to the maximum, after faster
        doubled = {p_fast, 1'b0};
        if (rise[BTN_SLOW] && (p_fast < max_period)) begin
          period_next    = (doubled > {1'b0, max_period}) ? max_period
                                                          : doubled[PERIOD_W-1:0];
          countdown_next = period_next;
        end
      end
    end

    // a new initial period loads period and counter straight away
    if (cfg.we && (cfg.index == CFG_INITIAL_PERIOD)) begin
      period_next    = cfg.data;
      countdown_next = cfg.data;
    end
  end

  // Result from the updated state; wider rings show the low LEDs only
  assign pattern_ext = {{LED_OUT_W{1'b0}}, pattern_next};

  always_comb begin
    result.leds        = pattern_ext[LED_OUT_W-1:0];
    result.stepped     = stepped;
    result.is_running  = run_flag_next;
    result.reverse     = dir_flag_next;
    result.step_period = period_next;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= NUM_LEDS'(1);
      run_flag       <= 1'b1;
      dir_flag       <= 1'b0;
      period         <= INITIAL_PERIOD_RST;
      countdown      <= INITIAL_PERIOD_RST;
      last_buttons   <= '0;
      min_period     <= MIN_PERIOD_RST;
      max_period     <= MAX_PERIOD_RST;
    end else begin
      pattern      <= pattern_next;
      run_flag     <= run_flag_next;
      dir_flag     <= dir_flag_next;
      period       <= period_next;
      countdown    <= countdown_next;
      last_buttons <= last_buttons_next;
      if (cfg.we) begin
        case (cfg.index)
          CFG_INITIAL_PERIOD: ;  // goes straight into period and counter
          CFG_MIN_PERIOD:     min_period     <= cfg.data;
          CFG_MAX_PERIOD:     max_period     <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // the light is a single lit LED
  `RLSC_ASSERT(a_pattern_onehot, $onehot(pattern), "LED pattern is not one-hot")
  // a step always moves the lit LED
  `RLSC_ASSERT(a_step_moves, stepped |=> (pattern != $past(pattern)),
               "step left the pattern unchanged")
  // button samples never move the light
  `RLSC_ASSERT(a_button_holds, (fire && item.req_type == REQ_BUTTON) |=> $stable(pattern),
               "button sample moved the light")
  // an expired count reloads the period
  `RLSC_ASSERT(a_reload_period, (fire && item.req_type == REQ_TICK && countdown <= PERIOD_W'(1))
               |=> (countdown == period), "expired count did not reload the period")

endmodule

>>> rtl/core/rlsc_out_buf.sv
`include "running_light_speed_controller_defines.svh"

module rlsc_out_buf
  import rlsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    can_load,
  output logic    valid,
  input  logic    ready,
  output result_t result
);

  // Free when empty or when the held result leaves this cycle
  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

  // never overwrite a result that is still waiting
  `RLSC_ASSERT_ALWAYS(a_no_overwrite, load |-> can_load, "result overwritten before taken")
  // a load always leaves a result on show
  `RLSC_ASSERT(a_load_shows, load |=> valid, "loaded result not shown")
  // a waiting result stays until taken
  `RLSC_ASSERT(a_wait_holds, (valid && !ready) |=> valid, "waiting result dropped")

endmodule

>>> rtl/core/running_light_speed_controller.sv
// Running light speed controller: one lit LED steps round a ring, paced by a
// down counter that a tick request decrements; button requests toggle run and
// direction and halve or double the step period within min_period and
// max_period. Every request gives exactly one result. A request sits in the
// input register while its state update and result are formed, and the
// result moves into the output register once that register can load, so a
// held-off output keeps it waiting in the input register. One request is taken
// every cycle while m_tready is high; only a held-off output stalls the
// input. Write the period registers only while no request is in flight.
module running_light_speed_controller
  import rlsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] buttons, [7:4] zero
  input  logic                 s_tuser,   // [0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // [3:0] leds, [4] stepped, [5] is_running,
                                          // [6] reverse, [37:7] step_period, [39:38] zero
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data
);

  logic    in_valid;
  item_t   in_item;
  logic    fire;
  logic    can_load;
  cfg_wr_t cfg;
  result_t step_result;
  result_t out_result;

  assign fire     = in_valid && can_load;
  assign s_tready = !in_valid || fire;

  // Input request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type <= s_tuser;
      in_item.buttons  <= s_tdata[BUTTON_W-1:0];
    end
  end

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  rlsc_step u_step (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (in_item),
    .result (step_result)
  );

  rlsc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result_in (step_result),
    .can_load  (can_load),
    .valid     (m_tvalid),
    .ready     (m_tready),
    .result    (out_result)
  );

  assign m_tdata = {2'b00, out_result};

endmodule
